FILE: rtl/dle_stx_frame_receiver_unit_assert.svh
`ifndef DLE_STX_FRAME_RECEIVER_UNIT_ASSERT_SVH
`define DLE_STX_FRAME_RECEIVER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define DSFR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define DSFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define DSFR_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define DSFR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/dsfr_pkg.sv
package dsfr_pkg;

    localparam int MAX_PACKET = 64;
    localparam int CNT_W      = $clog2(MAX_PACKET + 1);
    localparam int CMP_W      = 10;
    localparam int TDATA_W    = 136;
    localparam int RES_W      = 131;

    localparam logic [7:0] DLE_BYTE      = 8'h10;
    localparam logic [7:0] STX_BYTE      = 8'h02;
    localparam logic [7:0] ETX_BYTE      = 8'h03;
    localparam logic [7:0] MIN_FORCE_LEN = 8'd19;
    localparam logic [7:0] DATA_ERR_MASK = 8'h07;
    localparam int         NUM_AXES      = 6;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_DLE  = 2'd1,
        PH_LEN  = 2'd2,
        PH_DATA = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        CFG_STATUS_OK = 2'd0,
        CFG_HANDSHAKE = 2'd1,
        CFG_STREAM    = 2'd2
    } t_cfg_index;

    typedef enum logic [2:0] {
        RC_FORCE_OK   = 3'd0,
        RC_OTHER_OK   = 3'd1,
        RC_BAD_TRAIL  = 3'd2,
        RC_BCC_ERR    = 3'd3,
        RC_OVERFLOW   = 3'd4,
        RC_STATUS_BAD = 3'd5,
        RC_DATA_ERR   = 3'd6,
        RC_SHORT      = 3'd7
    } t_code;

    typedef struct packed {
        logic [7:0] status_ok_code;
        logic [7:0] handshake_command;
        logic [7:0] stream_command;
    } t_cfg;

    // Lowest field last so the packed word matches the stream layout.
    typedef struct packed {
        logic        [7:0]  sensor_status;
        logic signed [15:0] moment_z;
        logic signed [15:0] moment_y;
        logic signed [15:0] moment_x;
        logic signed [15:0] force_z;
        logic signed [15:0] force_y;
        logic signed [15:0] force_x;
        logic        [7:0]  response_status;
        logic        [7:0]  command_code;
        logic        [7:0]  payload_length;
        t_code              result_code;
    } t_result;

endpackage

FILE: rtl/dsfr_parser.sv
module dsfr_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_byte_valid,
    input  logic [7:0]        i_byte,
    input  dsfr_pkg::t_cfg    i_cfg,
    output logic              o_res_valid,
    output dsfr_pkg::t_result o_res
);
    import dsfr_pkg::*;

    t_phase             r_phase, n_phase;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [7:0]         r_len, n_len;
    logic [7:0]         r_bcc, n_bcc;
    logic [7:0]         r_hdr [3];
    logic [7:0]         n_hdr [3];
    logic [15:0]        r_axis [NUM_AXES];
    logic [15:0]        n_axis [NUM_AXES];
    logic [7:0]         r_hold, n_hold;
    logic               r_trail_ok, n_trail_ok;
    logic [7:0]         r_dstat, n_dstat;

    logic [CMP_W-1:0]   pos;
    logic [CMP_W-1:0]   len_w;
    logic [CMP_W-1:0]   p;
    logic               at_max;
    logic               in_payload;
    logic               at_dle;
    logic               at_etx;
    logic               at_bcc;
    logic               is_force_cmd;
    t_code              code;
    logic               show_axes;
    logic               show_dstat;

    assign pos        = CMP_W'(r_count);
    assign len_w      = CMP_W'(r_len);
    assign p          = pos - CMP_W'(3);
    assign at_max     = r_count >= CNT_W'(MAX_PACKET);
    assign in_payload = pos < len_w + CMP_W'(3);
    assign at_dle     = pos == len_w + CMP_W'(3);
    assign at_etx     = pos == len_w + CMP_W'(4);
    assign at_bcc     = !in_payload && !at_dle && !at_etx;
    assign is_force_cmd = (r_hdr[1] == i_cfg.handshake_command)
                       || (r_hdr[1] == i_cfg.stream_command);

    always_comb begin
        n_phase = r_phase;
        if (i_byte_valid) begin
            unique case (r_phase)
                PH_IDLE: if (i_byte == DLE_BYTE) n_phase = PH_DLE;
                PH_DLE:  n_phase = (i_byte == STX_BYTE) ? PH_LEN : PH_IDLE;
                PH_LEN:  n_phase = PH_DATA;
                PH_DATA: if (at_max || at_bcc) n_phase = PH_IDLE;
                default: n_phase = PH_IDLE;
            endcase
        end
    end

    always_comb begin
        priority if (!r_trail_ok)                              code = RC_BAD_TRAIL;
        else if (r_bcc != i_byte)                              code = RC_BCC_ERR;
        else if (r_hdr[2] != i_cfg.status_ok_code)             code = RC_STATUS_BAD;
        else if (!is_force_cmd)                                code = RC_OTHER_OK;
        else if (r_len < MIN_FORCE_LEN)                        code = RC_SHORT;
        else if ((r_dstat & DATA_ERR_MASK) != 8'h00)           code = RC_DATA_ERR;
        else                                                   code = RC_FORCE_OK;
    end

    always_comb begin
        n_count    = r_count;
        n_len      = r_len;
        n_bcc      = r_bcc;
        n_hdr      = r_hdr;
        n_axis     = r_axis;
        n_hold     = r_hold;
        n_trail_ok = r_trail_ok;
        n_dstat    = r_dstat;
        o_res_valid = 1'b0;
        o_res.result_code = at_max ? RC_OVERFLOW : code;
        show_axes  = !at_max && (code == RC_FORCE_OK);
        show_dstat = !at_max && ((code == RC_FORCE_OK) || (code == RC_DATA_ERR));

        if (i_byte_valid) begin
            unique case (r_phase)
                PH_DLE: begin
                    if (i_byte == STX_BYTE) begin
                        n_count    = CNT_W'(2);
                        n_len      = 8'h00;
                        n_bcc      = 8'h00;
                        n_hdr      = '{default: 8'h00};
                        n_axis     = '{default: 16'h0000};
                        n_hold     = 8'h00;
                        n_trail_ok = 1'b1;
                        n_dstat    = 8'h00;
                    end
                end
                PH_LEN: begin
                    n_len   = i_byte;
                    n_bcc   = (i_byte == DLE_BYTE) ? 8'h00 : i_byte;
                    n_count = CNT_W'(3);
                end
                PH_DATA: begin
                    if (at_max) begin
                        o_res_valid = 1'b1;
                    end else begin
                        n_count = r_count + CNT_W'(1);
                        if (in_payload) begin
                            if (i_byte != DLE_BYTE) n_bcc = r_bcc ^ i_byte;
                            for (int k = 0; k < 3; k++) begin
                                if (p == CMP_W'(k)) n_hdr[k] = i_byte;
                            end
                            for (int k = 0; k < NUM_AXES; k++) begin
                                if (p == CMP_W'(3 + 2 * k)) n_hold = i_byte;
                                if (p == CMP_W'(4 + 2 * k)) n_axis[k] = {i_byte, r_hold};
                            end
                            if ((r_len >= 8'd2) && (p == len_w - CMP_W'(2))) begin
                                n_dstat = i_byte;
                            end
                        end else if (at_dle) begin
                            if (i_byte != DLE_BYTE) n_trail_ok = 1'b0;
                        end else if (at_etx) begin
                            if (i_byte != ETX_BYTE) n_trail_ok = 1'b0;
                        end else begin
                            o_res_valid = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end

        o_res.payload_length  = r_len;
        o_res.command_code    = r_hdr[1];
        o_res.response_status = r_hdr[2];
        o_res.force_x  = show_axes ? r_axis[0] : 16'h0000;
        o_res.force_y  = show_axes ? r_axis[1] : 16'h0000;
        o_res.force_z  = show_axes ? r_axis[2] : 16'h0000;
        o_res.moment_x = show_axes ? r_axis[3] : 16'h0000;
        o_res.moment_y = show_axes ? r_axis[4] : 16'h0000;
        o_res.moment_z = show_axes ? r_axis[5] : 16'h0000;
        o_res.sensor_status = show_dstat ? r_dstat : 8'h00;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_count    <= '0;
            r_trail_ok <= 1'b1;
        end else begin
            r_phase    <= n_phase;
            r_count    <= n_count;
            r_trail_ok <= n_trail_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len   <= n_len;
        r_bcc   <= n_bcc;
        r_hdr   <= n_hdr;
        r_axis  <= n_axis;
        r_hold  <= n_hold;
        r_dstat <= n_dstat;
    end

endmodule

FILE: rtl/dle_stx_frame_receiver_unit.sv
// Receives one serial byte per transaction and decodes DLE STX LEN payload
// DLE ETX BCC frames; each complete, broken or overflowing frame yields one
// result transaction. The block takes one byte every cycle: the frame state
// and checks advance in the cycle the byte is accepted, and the result sits in
// a single output register. Input ready drops only while a result waits in
// that register and the downstream side holds tready low.
module dle_stx_frame_receiver_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // [7:0] rx_byte
    input  logic [7:0]                  i_s_axis_tdata,
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // [2:0] result_code, [10:3] payload_length, [18:11] command_code,
    // [26:19] response_status, [42:27] force_x, [58:43] force_y,
    // [74:59] force_z, [90:75] moment_x, [106:91] moment_y,
    // [122:107] moment_z, [130:123] sensor_status, [135:131] zero
    output logic [dsfr_pkg::TDATA_W-1:0] o_m_axis_tdata,
    input  logic                        i_cfg_wr_en,
    input  logic [1:0]                  i_cfg_index,
    input  logic [7:0]                  i_cfg_data
);
    import dsfr_pkg::*;

    `include "dle_stx_frame_receiver_unit_assert.svh"

    t_cfg    r_cfg;
    logic    r_m_valid;
    t_result r_result;
    logic    s_accept;
    logic    res_valid;
    t_result res;

    assign o_s_axis_tready = !r_m_valid || i_m_axis_tready;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {(TDATA_W - RES_W)'(0), r_result};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.status_ok_code    <= 8'd0;
            r_cfg.handshake_command <= 8'd48;
            r_cfg.stream_command    <= 8'd64;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_STATUS_OK: r_cfg.status_ok_code    <= i_cfg_data;
                CFG_HANDSHAKE: r_cfg.handshake_command <= i_cfg_data;
                CFG_STREAM:    r_cfg.stream_command    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    dsfr_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_valid (s_accept),
        .i_byte       (i_s_axis_tdata),
        .i_cfg        (r_cfg),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_m_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && res_valid) r_result <= res;
    end

    `DSFR_ASSERT_NEXT(a_result_needs_byte, i_clk, i_rst_n,
        !r_m_valid && !s_accept, !r_m_valid)
    `DSFR_ASSERT_IMPLY(a_axes_only_on_ok, i_clk, i_rst_n,
        r_m_valid && r_result.result_code != RC_FORCE_OK,
        r_result.force_x == 16'h0000 && r_result.moment_z == 16'h0000)
    `DSFR_ASSERT_IMPLY(a_dstat_gated, i_clk, i_rst_n,
        r_m_valid && r_result.result_code != RC_FORCE_OK
            && r_result.result_code != RC_DATA_ERR,
        r_result.sensor_status == 8'h00)

endmodule
